[design/bggg_pkg.sv]
// Shared types, constants and the gamma table of the banded gradient generator.
`default_nettype none

package bggg_pkg;

  // Field and register widths.
  localparam int CH_W         = 8;
  localparam int NUM_CH       = 4;
  localparam int FRAC_W       = 16;
  localparam int LEVEL_W      = CH_W + FRAC_W + 2;
  localparam int DIM_REG_W    = 13;
  localparam int DIM_REG_MAX  = (1 << DIM_REG_W) - 1;
  localparam int CFG_DATA_W   = 32;
  localparam int REG_INDEX_W  = 3;
  localparam int IN_DATA_W    = 8;
  localparam int OUT_DATA_W   = NUM_CH * CH_W;
  localparam int DIV_NUM_W    = CH_W + FRAC_W;

  // Gamma table: Q8.8 entries, indexed by the integer part of a level.
  localparam int GAMMA_ENTRIES = 257;
  localparam int GAMMA_IDX_W   = $clog2(GAMMA_ENTRIES);
  localparam int GAMMA_W       = 16;
  localparam int GAMMA_FRAC_W  = 8;
  localparam int GAMMA_SHIFT   = FRAC_W + GAMMA_FRAC_W;
  localparam int GAMMA_SUM_W   = GAMMA_W + FRAC_W + 1;

  localparam int MAX_DIM_DEFAULT = 4096;

  // Register reset values.
  localparam logic [CFG_DATA_W-1:0] START_COLOR_RESET  = 32'h0000_0000;
  localparam logic [CFG_DATA_W-1:0] END_COLOR_RESET    = 32'hFFFF_FFFF;
  localparam logic [DIM_REG_W-1:0]  FRAME_WIDTH_RESET  = 13'd1024;
  localparam logic [DIM_REG_W-1:0]  FRAME_HEIGHT_RESET = 13'd512;
  localparam logic [DIM_REG_W-1:0]  BAND_COUNT_RESET   = 13'd100;
  localparam logic                  WITH_ALPHA_RESET   = 1'b0;

  typedef enum logic [REG_INDEX_W-1:0] {
    REG_START_COLOR  = 3'd0,
    REG_END_COLOR    = 3'd1,
    REG_FRAME_WIDTH  = 3'd2,
    REG_FRAME_HEIGHT = 3'd3,
    REG_BAND_COUNT   = 3'd4,
    REG_WITH_ALPHA   = 3'd5
  } reg_index_t;

  typedef enum logic [1:0] {
    CH_BLUE  = 2'd0,
    CH_GREEN = 2'd1,
    CH_RED   = 2'd2,
    CH_ALPHA = 2'd3
  } channel_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INIT,
    ST_DIV_START,
    ST_DIV_WAIT,
    ST_SAMPLE,
    ST_MUL,
    ST_OUT
  } ctrl_state_t;

  typedef struct packed {
    logic     init;
    logic     div_start;
    logic     store_step;
    channel_t div_chan;
    logic     sample;
    logic     mul;
    logic     load_out;
  } ctrl_cmd_t;

  typedef struct packed {
    logic need_init;
    logic div_done;
  } dp_status_t;

  typedef logic [GAMMA_W-1:0] gamma_lut_t [GAMMA_ENTRIES];

  // Picks one 8-bit channel out of a packed colour for the selected layout.
  function automatic logic [CH_W-1:0] chan_of(input logic [CFG_DATA_W-1:0] color,
                                               input channel_t ch,
                                               input logic alpha_on);
    logic [CH_W-1:0] v;
    v = '0;
    if (alpha_on) begin
      unique case (ch)
        CH_BLUE:  v = color[15:8];
        CH_GREEN: v = color[23:16];
        CH_RED:   v = color[31:24];
        CH_ALPHA: v = color[7:0];
        default:  v = '0;
      endcase
    end else begin
      unique case (ch)
        CH_BLUE:  v = color[7:0];
        CH_GREEN: v = color[15:8];
        CH_RED:   v = color[23:16];
        CH_ALPHA: v = '0;
        default:  v = '0;
      endcase
    end
    return v;
  endfunction

  // Entry i is the largest Y with Y^11 <= 256^11 * 255^6 * i^5, i.e. the
  // curve 255*(v/255)^(1/2.2) in Q8.8. Evaluated once at elaboration.
  function automatic gamma_lut_t build_gamma_lut();
    gamma_lut_t lut;
    logic [191:0] rhs;
    logic [191:0] c1;
    logic [191:0] c2;
    logic [191:0] c4;
    logic [191:0] c8;
    logic [191:0] lhs;
    logic [GAMMA_W-1:0] y;
    logic [GAMMA_W-1:0] cand;
    int i;
    int k;
    int b;
    for (i = 0; i < GAMMA_ENTRIES; i++) begin
      rhs = 192'd1 << 88;
      for (k = 0; k < 6; k++) rhs = rhs * 192'd255;
      for (k = 0; k < 5; k++) rhs = rhs * 192'(i);
      y = '0;
      for (b = GAMMA_W - 1; b >= 0; b--) begin
        cand = y | (GAMMA_W'(1) << b);
        c1   = 192'(cand);
        c2   = c1 * c1;
        c4   = c2 * c2;
        c8   = c4 * c4;
        lhs  = c8 * c2 * c1;
        if (lhs <= rhs) y = cand;
      end
      lut[i] = y;
    end
    return lut;
  endfunction

  localparam gamma_lut_t GAMMA_LUT = build_gamma_lut();

endpackage

`default_nettype wire

[design/bggg_divider.sv]
// Restoring divider, one quotient bit per cycle, for the per-frame band steps.
`default_nettype none

module bggg_divider #(
  parameter int NUM_W = bggg_pkg::DIV_NUM_W,
  parameter int DEN_W = bggg_pkg::DIM_REG_W
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] dividend,
  input  logic [DEN_W-1:0] divisor,
  output logic [NUM_W-1:0] quotient,
  output logic             done
);

  localparam int CNT_W = $clog2(NUM_W);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [DEN_W-1:0] rem;
  logic [DEN_W-1:0] den;
  logic [NUM_W-1:0] quot;
  logic [DEN_W:0]   trial;
  logic             fits;

  assign trial    = {rem, quot[NUM_W-1]};
  assign fits     = trial >= {1'b0, den};
  assign quotient = quot;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(NUM_W - 1);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // The remainder stays below the divisor, so it always fits DEN_W bits.
  always_ff @(posedge clk) begin
    if (start) begin
      quot <= dividend;
      rem  <= '0;
      den  <= divisor;
    end else if (busy) begin
      rem  <= fits ? DEN_W'(trial - {1'b0, den}) : DEN_W'(trial);
      quot <= {quot[NUM_W-2:0], fits};
    end
  end

endmodule

`default_nettype wire

[design/bggg_datapath.sv]
// Datapath: registers, raster counters, band levels, step division and gamma lanes.
`default_nettype none

module bggg_datapath #(
  parameter int MAX_DIM = bggg_pkg::MAX_DIM_DEFAULT
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_write,
  input  logic [bggg_pkg::REG_INDEX_W-1:0]   cfg_index,
  input  logic [bggg_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  bggg_pkg::ctrl_cmd_t                cmd,
  output bggg_pkg::dp_status_t               status,
  output logic [bggg_pkg::OUT_DATA_W-1:0]    out_data,
  output logic                               out_last,
  output logic                               out_user
);

  import bggg_pkg::*;

  localparam int EFF_MAX = (MAX_DIM < DIM_REG_MAX) ? MAX_DIM : DIM_REG_MAX;
  localparam int EW      = $clog2(EFF_MAX + 1);
  localparam logic signed [LEVEL_W-1:0] LEVEL_MAX = LEVEL_W'(255 << FRAC_W);

  // Configuration registers.
  logic [CFG_DATA_W-1:0] start_color;
  logic [CFG_DATA_W-1:0] end_color;
  logic [DIM_REG_W-1:0]  frame_width;
  logic [DIM_REG_W-1:0]  frame_height;
  logic [DIM_REG_W-1:0]  band_count;
  logic                  with_alpha;

  // Frame state.
  logic [EW-1:0] eff_w;
  logic [EW-1:0] eff_h;
  logic [EW-1:0] eff_b;
  logic [EW-1:0] column;
  logic [EW-1:0] row;
  logic [EW-1:0] band_residue;
  logic          frame_start;
  logic signed [LEVEL_W-1:0] channel_level [NUM_CH];
  logic signed [LEVEL_W-1:0] channel_step  [NUM_CH];

  function automatic logic [EW-1:0] clamp_dim(input logic [DIM_REG_W-1:0] v);
    if (v == '0) return EW'(1);
    else if (32'(v) > 32'(MAX_DIM)) return EW'(MAX_DIM);
    else return EW'(v);
  endfunction

  function automatic logic [EW-1:0] clamp_band(input logic [DIM_REG_W-1:0] bc,
                                               input logic [EW-1:0] h);
    logic [DIM_REG_W-1:0] b;
    b = (bc == '0) ? DIM_REG_W'(1) : bc;
    if (32'(b) > 32'(h)) return h;
    else return EW'(b);
  endfunction

  logic [EW-1:0] eff_w_new;
  logic [EW-1:0] eff_h_new;
  logic [EW-1:0] eff_b_new;

  assign eff_w_new = clamp_dim(frame_width);
  assign eff_h_new = clamp_dim(frame_height);
  assign eff_b_new = clamp_band(band_count, eff_h_new);

  // Step division for the channel the controller selects.
  logic [CH_W-1:0]      div_s;
  logic [CH_W-1:0]      div_e;
  logic [CH_W:0]        diff;
  logic [CH_W:0]        diff_neg_full;
  logic                 diff_neg;
  logic [CH_W-1:0]      diff_mag;
  logic [DIV_NUM_W-1:0] div_quot;
  logic                 div_done;
  logic [LEVEL_W-1:0]   q_ext;
  logic [LEVEL_W-1:0]   step_value;

  assign div_s         = chan_of(start_color, cmd.div_chan, with_alpha);
  assign div_e         = chan_of(end_color, cmd.div_chan, with_alpha);
  assign diff          = {1'b0, div_e} - {1'b0, div_s};
  assign diff_neg      = diff[CH_W];
  assign diff_neg_full = ~diff + 1'b1;
  assign diff_mag      = diff_neg ? diff_neg_full[CH_W-1:0] : diff[CH_W-1:0];
  assign q_ext         = LEVEL_W'(div_quot);
  assign step_value    = diff_neg ? (~q_ext + 1'b1) : q_ext;

  bggg_divider #(
    .NUM_W (DIV_NUM_W),
    .DEN_W (EW)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend ({diff_mag, {FRAC_W{1'b0}}}),
    .divisor  (eff_b),
    .quotient (div_quot),
    .done     (div_done)
  );

  assign status.need_init = frame_start;
  assign status.div_done  = div_done;

  // Raster position decisions for the item being sampled.
  logic [EW:0] col_inc;
  logic [EW:0] row_inc;
  logic [EW:0] res_sum;
  logic        eor;
  logic        eof;
  logic        band_wrap;

  assign col_inc   = {1'b0, column} + 1'b1;
  assign row_inc   = {1'b0, row} + 1'b1;
  assign res_sum   = {1'b0, band_residue} + {1'b0, eff_b};
  assign eor       = col_inc >= {1'b0, eff_w};
  assign eof       = eor && (row_inc >= {1'b0, eff_h});
  assign band_wrap = res_sum >= {1'b0, eff_h};

  always_ff @(posedge clk) begin
    if (rst) begin
      start_color  <= START_COLOR_RESET;
      end_color    <= END_COLOR_RESET;
      frame_width  <= FRAME_WIDTH_RESET;
      frame_height <= FRAME_HEIGHT_RESET;
      band_count   <= BAND_COUNT_RESET;
      with_alpha   <= WITH_ALPHA_RESET;
      eff_w        <= clamp_dim(FRAME_WIDTH_RESET);
      eff_h        <= clamp_dim(FRAME_HEIGHT_RESET);
      eff_b        <= clamp_band(BAND_COUNT_RESET, clamp_dim(FRAME_HEIGHT_RESET));
      column       <= '0;
      row          <= '0;
      band_residue <= '0;
      frame_start  <= 1'b1;
      for (int c = 0; c < NUM_CH; c++) begin
        channel_level[c] <= LEVEL_W'({chan_of(START_COLOR_RESET, channel_t'(c),
                                              WITH_ALPHA_RESET), {FRAC_W{1'b0}}});
        channel_step[c]  <= '0;
      end
    end else begin
      if (cfg_write) begin
        unique case (cfg_index)
          REG_START_COLOR:  start_color  <= cfg_data;
          REG_END_COLOR:    end_color    <= cfg_data;
          REG_FRAME_WIDTH:  frame_width  <= cfg_data[DIM_REG_W-1:0];
          REG_FRAME_HEIGHT: frame_height <= cfg_data[DIM_REG_W-1:0];
          REG_BAND_COUNT:   band_count   <= cfg_data[DIM_REG_W-1:0];
          REG_WITH_ALPHA:   with_alpha   <= cfg_data[0];
          default: ;
        endcase
      end
      if (cmd.init) begin
        eff_w        <= eff_w_new;
        eff_h        <= eff_h_new;
        eff_b        <= eff_b_new;
        column       <= '0;
        row          <= '0;
        band_residue <= '0;
        frame_start  <= 1'b0;
        for (int c = 0; c < NUM_CH; c++) begin
          channel_level[c] <= LEVEL_W'({chan_of(start_color, channel_t'(c), with_alpha),
                                        {FRAC_W{1'b0}}});
        end
      end
      if (cmd.store_step) begin
        channel_step[cmd.div_chan] <= step_value;
      end
      // The levels are captured by the gamma lanes in this same cycle,
      // so the band advance below only affects the next item.
      if (cmd.sample) begin
        if (!eor) begin
          column <= EW'(col_inc);
        end else if (eof) begin
          frame_start <= 1'b1;
        end else begin
          column <= '0;
          row    <= EW'(row_inc);
          if (band_wrap) begin
            band_residue <= EW'(res_sum - {1'b0, eff_h});
            for (int c = 0; c < NUM_CH; c++) begin
              channel_level[c] <= channel_level[c] + channel_step[c];
            end
          end else begin
            band_residue <= EW'(res_sum);
          end
        end
      end
    end
  end

  // Gamma lanes: clamp and table lookup, then interpolation multiply, then sum.
  logic signed [LEVEL_W-1:0] lvl_clamped [NUM_CH];
  logic [GAMMA_IDX_W-1:0]    lut_idx     [NUM_CH];
  logic [GAMMA_W-1:0]        lut_lo      [NUM_CH];
  logic [GAMMA_W-1:0]        lut_hi      [NUM_CH];

  always_comb begin
    for (int c = 0; c < NUM_CH; c++) begin
      if (channel_level[c] < 0) begin
        lvl_clamped[c] = '0;
      end else if (channel_level[c] > LEVEL_MAX) begin
        lvl_clamped[c] = LEVEL_MAX;
      end else begin
        lvl_clamped[c] = channel_level[c];
      end
      lut_idx[c] = {1'b0, lvl_clamped[c][FRAC_W +: CH_W]};
      lut_lo[c]  = GAMMA_LUT[lut_idx[c]];
      lut_hi[c]  = GAMMA_LUT[lut_idx[c] + 1'b1];
    end
  end

  logic [GAMMA_W-1:0]         g_base  [NUM_CH];
  logic [GAMMA_W-1:0]         g_delta [NUM_CH];
  logic [FRAC_W-1:0]          g_frac  [NUM_CH];
  logic [GAMMA_W-1:0]         m_base  [NUM_CH];
  logic [GAMMA_W+FRAC_W-1:0]  m_prod  [NUM_CH];
  logic                       eor_s;
  logic                       eof_s;
  logic                       eor_m;
  logic                       eof_m;
  logic [GAMMA_SUM_W-1:0]     g_sum   [NUM_CH];
  logic [CH_W:0]              g_top   [NUM_CH];
  logic [CH_W-1:0]            g_out   [NUM_CH];

  // The table rises monotonically, so the upper entry minus the lower is never negative.
  always_ff @(posedge clk) begin
    if (cmd.sample) begin
      for (int c = 0; c < NUM_CH; c++) begin
        g_base[c]  <= lut_lo[c];
        g_delta[c] <= lut_hi[c] - lut_lo[c];
        g_frac[c]  <= lvl_clamped[c][FRAC_W-1:0];
      end
      eor_s <= eor;
      eof_s <= eof;
    end
    if (cmd.mul) begin
      for (int c = 0; c < NUM_CH; c++) begin
        m_base[c] <= g_base[c];
        m_prod[c] <= g_delta[c] * g_frac[c];
      end
      eor_m <= eor_s;
      eof_m <= eof_s;
    end
  end

  always_comb begin
    for (int c = 0; c < NUM_CH; c++) begin
      g_sum[c] = GAMMA_SUM_W'({m_base[c], {FRAC_W{1'b0}}}) + GAMMA_SUM_W'(m_prod[c]);
      g_top[c] = g_sum[c][GAMMA_SUM_W-1:GAMMA_SHIFT];
      g_out[c] = g_top[c][CH_W] ? {CH_W{1'b1}} : g_top[c][CH_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_data[CH_W*CH_BLUE  +: CH_W] <= g_out[CH_BLUE];
      out_data[CH_W*CH_GREEN +: CH_W] <= g_out[CH_GREEN];
      out_data[CH_W*CH_RED   +: CH_W] <= g_out[CH_RED];
      out_data[CH_W*CH_ALPHA +: CH_W] <= with_alpha ? g_out[CH_ALPHA] : '0;
      out_last <= eor_m;
      out_user <= eof_m;
    end
  end

`ifndef ASSERT_OFF
  a_residue_below_height: assert property (@(posedge clk) disable iff (rst)
    band_residue < eff_h)
    else $error("band residue reached the frame height");
`endif

endmodule

`default_nettype wire

[design/bggg_ctrl.sv]
// Controller: sequences frame setup, step divisions, gamma stages and the output register.
`default_nettype none

module bggg_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic                 restart,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  input  bggg_pkg::dp_status_t status,
  output bggg_pkg::ctrl_cmd_t  cmd
);

  import bggg_pkg::*;

  ctrl_state_t state;
  ctrl_state_t state_next;
  channel_t    chan;
  channel_t    chan_next;
  logic        out_valid;
  logic        out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      chan      <= CH_BLUE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      chan      <= chan_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next   = state;
    chan_next    = chan;
    cmd          = '0;
    cmd.div_chan = chan;
    unique case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          state_next = (restart || status.need_init) ? ST_INIT : ST_SAMPLE;
        end
      end
      ST_INIT: begin
        cmd.init   = 1'b1;
        chan_next  = CH_BLUE;
        state_next = ST_DIV_START;
      end
      ST_DIV_START: begin
        cmd.div_start = 1'b1;
        state_next    = ST_DIV_WAIT;
      end
      ST_DIV_WAIT: begin
        if (status.div_done) begin
          cmd.store_step = 1'b1;
          if (chan == CH_ALPHA) begin
            state_next = ST_SAMPLE;
          end else begin
            chan_next  = channel_t'(chan + 2'd1);
            state_next = ST_DIV_START;
          end
        end
      end
      ST_SAMPLE: begin
        cmd.sample = 1'b1;
        state_next = ST_MUL;
      end
      ST_MUL: begin
        cmd.mul    = 1'b1;
        state_next = ST_OUT;
      end
      ST_OUT: begin
        if (!out_valid || m_tready) begin
          cmd.load_out = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    if (cmd.load_out) begin
      out_valid_next = 1'b1;
    end else if (m_tready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  assign s_tready = (state == ST_IDLE);
  assign m_tvalid = out_valid;

`ifndef ASSERT_OFF
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> (!out_valid || m_tready))
    else $error("output register loaded while an item still waits");

  a_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    status.div_done |-> (state == ST_DIV_WAIT))
    else $error("divider finished outside the wait state");

  a_mul_after_sample: assert property (@(posedge clk) disable iff (rst)
    (state == ST_MUL) |-> ($past(state) == ST_SAMPLE))
    else $error("multiply stage entered without a sample");

  a_init_on_frame_start: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE && s_tvalid && status.need_init) |=> (state == ST_INIT))
    else $error("frame start item skipped the setup");
`endif

endmodule

`default_nettype wire

[design/banded_gradient_gamma_generator.sv]
// Top level of the banded vertical gradient pattern source with gamma correction.
//
// Channel  Side    Handshake                Contents
// cfg      in      cfg_valid / cfg_ready    cfg_index register number, cfg_data value
// s        in      s_tvalid / s_tready      tdata[0] restart, one item per pixel wanted
// m        out     m_tvalid / m_tready      tdata B,G,R,A bytes; tlast end of row;
//                                           tuser end of frame
//
// An ordinary item passes through accept, table lookup, interpolation multiply and
// output load in turn. The first item of a frame also runs frame setup and four step
// divisions through the one shared divider.
// Reset is synchronous and leaves the block idle with the register defaults loaded.
// A result waits in the output register while the next item is already being accepted;
// the last stage holds only if that register is still full and not being taken.
`default_nettype none

module banded_gradient_gamma_generator #(
  parameter int MAX_DIM = bggg_pkg::MAX_DIM_DEFAULT
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [bggg_pkg::REG_INDEX_W-1:0]  cfg_index,
  input  logic [bggg_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [bggg_pkg::IN_DATA_W-1:0]    s_tdata,   // [0] restart, [7:1] zero
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [bggg_pkg::OUT_DATA_W-1:0]   m_tdata,   // [7:0] blue, [15:8] green,
                                                       // [23:16] red, [31:24] alpha
  output logic                              m_tlast,   // end_of_row
  output logic                              m_tuser    // [0] end_of_frame
);

  import bggg_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  assign cfg_ready = 1'b1;

  bggg_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .restart  (s_tdata[0]),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .status   (status),
    .cmd      (cmd)
  );

  bggg_datapath #(
    .MAX_DIM (MAX_DIM)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .status    (status),
    .out_data  (m_tdata),
    .out_last  (m_tlast),
    .out_user  (m_tuser)
  );

endmodule

`default_nettype wire

[tb/sv/tb_banded_gradient_gamma_generator.sv]
// Self-checking testbench for the banded gradient generator with gamma correction.
`timescale 1ns / 1ps

module tb_banded_gradient_gamma_generator;
  import bggg_pkg::*;

  localparam logic [REG_INDEX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [REG_INDEX_W-1:0] REG_SPARE_HI = 3'd7;
  localparam int MAX_SIDE      = 4096;
  localparam int HOLD_CYCLES   = 400;
  localparam int SETTLE_CYCLES = 150;
  localparam int MAX_REPORTS   = 100;
  localparam int DIRECTED_ROWS = 42;

  typedef struct packed {
    logic [CH_W-1:0] blue;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] alpha;
    logic            row_end;
    logic            frame_end;
  } pixel_t;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

  typedef struct packed {
    row_kind_t              kind;
    logic [REG_INDEX_W-1:0] index;
    logic [CFG_DATA_W-1:0]  value;
    logic                   restart;
    logic                   typed;
    pixel_t                 want;
  } row_t;

  localparam pixel_t PX_DARK = '0;
  localparam pixel_t PX_FULL = '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1, 1'b1};

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [REG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [IN_DATA_W-1:0]   s_tdata = '0;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [OUT_DATA_W-1:0]  m_tdata;
  logic                   m_tlast;
  logic                   m_tuser;

  banded_gradient_gamma_generator u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .m_tuser   (m_tuser)
  );

  always #5 clk = ~clk;

  // Registers as the block should hold them.
  logic [CFG_DATA_W-1:0] start_reg;
  logic [CFG_DATA_W-1:0] end_reg;
  logic [DIM_REG_W-1:0]  width_reg;
  logic [DIM_REG_W-1:0]  height_reg;
  logic [DIM_REG_W-1:0]  bands_reg;
  logic                  alpha_reg;

  // Frame state: position, band accumulator and Q8.16 channel levels.
  int col_pos;
  int row_pos;
  int band_acc;
  int eff_width;
  int eff_height;
  int eff_bands;
  int level [NUM_CH];
  int step [NUM_CH];
  bit frame_due;

  int unsigned gamma_q88 [GAMMA_ENTRIES];
  pixel_t      pixels_due [$];
  pixel_t      oldest_due;
  int          mismatch_count = 0;
  int          sender_idle_pct = 31;
  int          recv_idle_pct = 53;
  int          holds_asked = 0;
  int          holds_served = 0;
  int          hold_left = 0;

  function automatic int colour_byte(input logic [CFG_DATA_W-1:0] colour, input int ch,
                                     input logic rgba);
    if (rgba)
      return (ch == CH_ALPHA) ? int'(colour[7:0]) : int'((colour >> (8 * (ch + 1))) & 32'hFF);
    if (ch == CH_ALPHA)
      return 0;
    return int'((colour >> (8 * ch)) & 32'hFF);
  endfunction

  function automatic int side_of(input logic [DIM_REG_W-1:0] v);
    if (v == 0)
      return 1;
    if (v > MAX_SIDE)
      return MAX_SIDE;
    return int'(v);
  endfunction

  // Table lookup with linear interpolation on the 16 fraction bits.
  function automatic logic [CH_W-1:0] gamma_out(input int lvl);
    int     idx;
    int     frac;
    longint acc;
    if (lvl < 0)
      lvl = 0;
    if (lvl > 255 * 65536)
      lvl = 255 * 65536;
    idx  = lvl >>> 16;
    frac = lvl & 32'hFFFF;
    acc  = longint'(gamma_q88[idx]) * (65536 - frac) + longint'(gamma_q88[idx + 1]) * frac;
    acc  = acc >>> 24;
    return (acc > 255) ? 8'hFF : acc[CH_W-1:0];
  endfunction

  function automatic pixel_t predict_pixel(input logic restart);
    pixel_t px;
    int     c;
    int     s;
    int     e;
    if (restart || frame_due) begin
      frame_due  = 1'b0;
      eff_width  = side_of(width_reg);
      eff_height = side_of(height_reg);
      eff_bands  = (bands_reg == 0) ? 1 : int'(bands_reg);
      if (eff_bands > eff_height)
        eff_bands = eff_height;
      col_pos  = 0;
      row_pos  = 0;
      band_acc = 0;
      for (c = 0; c < NUM_CH; c++) begin
        s        = colour_byte(start_reg, c, alpha_reg);
        e        = colour_byte(end_reg, c, alpha_reg);
        level[c] = s * 65536;
        step[c]  = ((e - s) * 65536) / eff_bands;
      end
    end
    px.blue      = gamma_out(level[CH_BLUE]);
    px.green     = gamma_out(level[CH_GREEN]);
    px.red       = gamma_out(level[CH_RED]);
    px.alpha     = alpha_reg ? gamma_out(level[CH_ALPHA]) : '0;
    px.row_end   = (col_pos + 1 >= eff_width);
    px.frame_end = px.row_end && (row_pos + 1 >= eff_height);
    if (!px.row_end) begin
      col_pos++;
    end else if (px.frame_end) begin
      frame_due = 1'b1;
    end else begin
      col_pos = 0;
      row_pos++;
      band_acc += eff_bands;
      if (band_acc >= eff_height) begin
        band_acc -= eff_height;
        for (c = 0; c < NUM_CH; c++)
          level[c] += step[c];
      end
    end
    return px;
  endfunction

  function automatic row_t typed_item(input logic restart, input pixel_t want);
    return '{ROW_ITEM, '0, '0, restart, 1'b1, want};
  endfunction

  function automatic row_t open_item(input logic restart);
    return '{ROW_ITEM, '0, '0, restart, 1'b0, PX_DARK};
  endfunction

  function automatic row_t cfg_row(input logic [REG_INDEX_W-1:0] index,
                                   input logic [CFG_DATA_W-1:0] value);
    return '{ROW_CFG, index, value, 1'b0, 1'b0, PX_DARK};
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_colour();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_side();
    case ($urandom_range(19))
      0:       return 0;
      1:       return $urandom_range(MAX_SIDE + 1, DIM_REG_MAX);
      2:       return MAX_SIDE;
      3, 4:    return $urandom_range(7, 40);
      default: return $urandom_range(1, 6);
    endcase
  endfunction

  task automatic report_mismatch(input string msg);
    if (mismatch_count < MAX_REPORTS)
      $display("%0t ns: mismatch: %s", $time, msg);
    mismatch_count++;
  endtask

  task automatic check_field(input string name, input int got, input int want);
    if (got != want)
      report_mismatch($sformatf("%s is %0d, expected %0d", name, got, want));
  endtask

  // Called just after a falling edge; returns just after the next one.
  task automatic write_reg(input logic [REG_INDEX_W-1:0] index,
                           input logic [CFG_DATA_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    case (index)
      REG_START_COLOR:  start_reg  = value;
      REG_END_COLOR:    end_reg    = value;
      REG_FRAME_WIDTH:  width_reg  = value[DIM_REG_W-1:0];
      REG_FRAME_HEIGHT: height_reg = value[DIM_REG_W-1:0];
      REG_BAND_COUNT:   bands_reg  = value[DIM_REG_W-1:0];
      REG_WITH_ALPHA:   alpha_reg  = value[0];
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic send_pixel(input logic restart, input logic typed, input pixel_t want);
    pixel_t guess;
    cfg_valid <= 1'b0;
    while ($urandom_range(99) < sender_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {{(IN_DATA_W-1){1'b0}}, restart};
    do @(posedge clk); while (!s_tready);
    guess = predict_pixel(restart);
    pixels_due.push_back(typed ? want : guess);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    s_tvalid  <= 1'b0;
    cfg_valid <= 1'b0;
    while (pixels_due.size() != 0)
      @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  // Output side: random back-pressure, with one long hold-off on request.
  initial begin
    forever begin
      @(negedge clk);
      if (holds_served != holds_asked) begin
        holds_served++;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (pixels_due.size() == 0) begin
        report_mismatch("pixel delivered with none pending");
      end else begin
        oldest_due = pixels_due.pop_front();
        check_field("blue", m_tdata[7:0], oldest_due.blue);
        check_field("green", m_tdata[15:8], oldest_due.green);
        check_field("red", m_tdata[23:16], oldest_due.red);
        check_field("alpha", m_tdata[31:24], oldest_due.alpha);
        check_field("end_of_row", m_tlast, oldest_due.row_end);
        check_field("end_of_frame", m_tuser, oldest_due.frame_end);
      end
    end
  end

  initial begin
    #10_000_000;
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    row_t         directed_rows [DIRECTED_ROWS];
    row_t         r;
    logic [191:0] bound;
    logic [191:0] power;
    logic [15:0]  y;
    logic [15:0]  cand;
    int           i;
    int           k;
    int           b;
    int           mode;
    int           ph;
    int           n;
    int           count;

    // Entry i is the largest Q8.8 value y with (y/256)^11 <= 255^6 * i^5.
    for (i = 0; i < GAMMA_ENTRIES; i++) begin
      bound = 192'd1 << 88;
      for (k = 0; k < 6; k++)
        bound = bound * 192'd255;
      for (k = 0; k < 5; k++)
        bound = bound * 192'(i);
      y = '0;
      for (b = 15; b >= 0; b--) begin
        cand  = y | (16'd1 << b);
        power = 192'd1;
        for (k = 0; k < 11; k++)
          power = power * 192'(cand);
        if (power <= bound)
          y = cand;
      end
      gamma_q88[i] = y;
    end

    start_reg  = START_COLOR_RESET;
    end_reg    = END_COLOR_RESET;
    width_reg  = FRAME_WIDTH_RESET;
    height_reg = FRAME_HEIGHT_RESET;
    bands_reg  = BAND_COUNT_RESET;
    alpha_reg  = WITH_ALPHA_RESET;
    col_pos    = 0;
    row_pos    = 0;
    band_acc   = 0;
    eff_width  = FRAME_WIDTH_RESET;
    eff_height = FRAME_HEIGHT_RESET;
    eff_bands  = BAND_COUNT_RESET;
    for (k = 0; k < NUM_CH; k++) begin
      level[k] = 0;
      step[k]  = 0;
    end
    frame_due = 1'b1;

    directed_rows = '{
      // Reset registers: black start colour, no alpha, wide frame.
      typed_item(1'b0, PX_DARK),
      typed_item(1'b1, PX_DARK),
      // White RGBA with zero dimensions: every item is a one-pixel frame.
      cfg_row(REG_START_COLOR, 32'hFFFF_FFFF),
      cfg_row(REG_WITH_ALPHA, 32'd1),
      cfg_row(REG_FRAME_WIDTH, 32'd0),
      cfg_row(REG_FRAME_HEIGHT, 32'd0),
      cfg_row(REG_BAND_COUNT, 32'd0),
      open_item(1'b0),
      typed_item(1'b1, PX_FULL),
      typed_item(1'b0, PX_FULL),
      // Writes beyond the register list leave everything unchanged.
      cfg_row(REG_SPARE_LO, 32'h0000_0007),
      cfg_row(REG_SPARE_HI, 32'hFFFF_FFFF),
      typed_item(1'b0, PX_FULL),
      // Oversized dimensions and band count are clamped.
      cfg_row(REG_START_COLOR, 32'h0000_0000),
      cfg_row(REG_FRAME_WIDTH, DIM_REG_MAX),
      cfg_row(REG_FRAME_HEIGHT, MAX_SIDE),
      cfg_row(REG_BAND_COUNT, DIM_REG_MAX),
      typed_item(1'b0, PX_DARK),
      open_item(1'b0),
      typed_item(1'b1, PX_DARK),
      // Small RGBA gradient with rising and falling channels.
      cfg_row(REG_FRAME_WIDTH, 32'd2),
      cfg_row(REG_FRAME_HEIGHT, 32'd4),
      cfg_row(REG_BAND_COUNT, 32'd3),
      cfg_row(REG_START_COLOR, 32'h10F0_8040),
      cfg_row(REG_END_COLOR, 32'hF010_40C0),
      open_item(1'b1),
      open_item(1'b0), open_item(1'b0), open_item(1'b0), open_item(1'b0),
      open_item(1'b0), open_item(1'b0), open_item(1'b0),
      open_item(1'b0),
      open_item(1'b0),
      open_item(1'b1),
      // RGB layout, and more bands than rows.
      cfg_row(REG_WITH_ALPHA, 32'd0),
      cfg_row(REG_BAND_COUNT, 32'd9),
      open_item(1'b1),
      open_item(1'b0), open_item(1'b0), open_item(1'b0)
    };

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    for (i = 0; i < DIRECTED_ROWS; i++) begin
      r = directed_rows[i];
      if (r.kind == ROW_CFG) begin
        wait_drained();
        write_reg(r.index, r.value);
      end else begin
        send_pixel(r.restart, r.typed, r.want);
      end
    end

    for (mode = 0; mode < 3; mode++) begin
      sender_idle_pct = (mode == 0) ? 31 : (mode == 1) ? 53 : 0;
      recv_idle_pct   = (mode == 0) ? 53 : (mode == 1) ? 31 : 0;
      for (ph = 0; ph < 5; ph++) begin
        wait_drained();
        if (ph == 0 || $urandom_range(9) < 6)
          write_reg(REG_START_COLOR, pick_colour());
        if (ph == 0 || $urandom_range(9) < 6)
          write_reg(REG_END_COLOR, pick_colour());
        if (ph == 0 || $urandom_range(9) < 6)
          write_reg(REG_FRAME_WIDTH, pick_side());
        if (ph == 0 || $urandom_range(9) < 6)
          write_reg(REG_FRAME_HEIGHT, pick_side());
        if (ph == 0 || $urandom_range(9) < 6) begin
          case ($urandom_range(9))
            0:       write_reg(REG_BAND_COUNT, 32'd0);
            1:       write_reg(REG_BAND_COUNT, $urandom_range(0, DIM_REG_MAX));
            2:       write_reg(REG_BAND_COUNT, (height_reg + $urandom_range(1, 4)) & DIM_REG_MAX);
            default: write_reg(REG_BAND_COUNT, $urandom_range(1, 8));
          endcase
        end
        if (ph == 0 || $urandom_range(9) < 6)
          write_reg(REG_WITH_ALPHA, $urandom_range(1));
        // The output stalls for a long stretch while items keep coming.
        if (mode == 0 && ph == 0)
          holds_asked++;
        count = $urandom_range(28, 38);
        for (n = 0; n < count; n++) begin
          if (mode == 1 && ph == 2 && n == count / 2)
            wait_drained();
          send_pixel($urandom_range(99) < 4, 1'b0, PX_DARK);
        end
      end
    end

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pixels_due.size() == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule

[files.f]
design/bggg_pkg.sv
design/bggg_divider.sv
design/bggg_datapath.sv
design/bggg_ctrl.sv
design/banded_gradient_gamma_generator.sv
tb/sv/tb_banded_gradient_gamma_generator.sv
